// ----- rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by the controller, datapath and top level.
package rrts_pkg;

   localparam int TASK_W   = 4;   // task index field width
   localparam int TIME_W   = 16;  // tick and burst width
   localparam int QUANT_W  = 8;   // quantum and slice counter width
   localparam int COUNT_W  = 5;   // task_count register width
   localparam int CSR_IW   = 4;   // configuration index width
   localparam int CSR_DW   = 8;   // configuration data width

   localparam logic [CSR_IW-1:0] CSR_QUANTUM    = 4'd0;
   localparam logic [CSR_IW-1:0] CSR_TASK_COUNT = 4'd1;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET    = 8'd2;
   localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 5'd1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;        // write a task entry from the request ports
      logic check;       // release or preempt the running task
      logic scan_clear;  // point the arrival scan at task 0
      logic scan_step;   // compare one arrival entry, advance scan
      logic dispatch;    // pop queue head if processor idle
      logic run;         // charge one tick, emit result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // scan sits on the last task in use
      logic count_zero;  // no task in use, skip the scan
      logic out_free;    // result register can take a new result
   } status_type;

endpackage

// ----- rtl/rrts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the task tables and the ready queue.
module rrts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rrts_ctrl.sv -----
// Sequencing state machine for the scheduler.
// Depends on rrts_pkg; drives rrts_dpath through cmd_type.
module rrts_ctrl
   import rrts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CHECK    = 7'b0000010,
      ST_SCAN     = 7'b0000100,
      ST_QWAIT    = 7'b0001000,
      ST_DISPATCH = 7'b0010000,
      ST_RWAIT    = 7'b0100000,
      ST_RUN      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_kind == KIND_LOAD) begin
               cmd.load = 1'b1;
            end
            if (req_valid && req_kind == KIND_TICK) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check      = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in = status.count_zero ? ST_QWAIT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_QWAIT;
            end
         end
         ST_QWAIT: begin
            state_in = ST_DISPATCH;   // queue head read settles
         end
         ST_DISPATCH: begin
            cmd.dispatch = 1'b1;
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            state_in = ST_RUN;        // remaining entry of new task settles
         end
         ST_RUN: begin
            if (status.out_free) begin
               cmd.run  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/rrts_dpath.sv -----
// Scheduler datapath: task tables, ready queue, counters, result register.
// Depends on rrts_pkg and rrts_ram; steered by rrts_ctrl via cmd_type.
module rrts_dpath
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [TASK_W-1:0]   req_task_index,
   input  logic [TIME_W-1:0]   req_arrival_time,
   input  logic [TIME_W-1:0]   req_burst_length,
   input  logic                csr_valid,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TIME_W-1:0]   rsp_current_time,
   output logic [TASK_W-1:0]   rsp_running_task,
   output logic                rsp_running_valid,
   output logic [TIME_W-1:0]   rsp_switch_count,
   output logic                rsp_all_done
);

   localparam int AW  = $clog2(MAX_TASKS);
   localparam int FW  = $clog2(MAX_TASKS + 1);
   // one spare bit so MAX_TASKS itself fits in the range compare
   localparam int IXW = ((AW > TASK_W) ? AW : TASK_W) + 1;
   localparam int CNW = $clog2(MAX_TASKS + 32) + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TASKS - 1);

   // configuration
   logic [QUANT_W-1:0] quantum_ff;
   logic [COUNT_W-1:0] task_count_ff;

   // scheduler state
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic               busy_ff, busy_in;
   logic [QUANT_W-1:0] slice_ff, slice_in;
   logic [TIME_W-1:0]  tick_ff, tick_in;
   logic [TIME_W-1:0]  preempt_ff, preempt_in;
   logic [TIME_W:0]    latest_ff, latest_in;
   logic [AW-1:0]      scan_ff, scan_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic [TASK_W-1:0]  rsp_task_ff;
   logic               rsp_run_ff;
   logic [TIME_W-1:0]  rsp_switch_ff;
   logic               rsp_done_ff;

   // memory ports
   logic [TIME_W-1:0]  arr_rd, rem_rd;
   logic [AW-1:0]      q_rd;
   logic               rem_we;
   logic [AW-1:0]      rem_wa;
   logic [TIME_W-1:0]  rem_wd;

   // misc
   logic [IXW-1:0]     idx_w;
   logic               load_ok;
   logic [AW-1:0]      load_addr;
   logic [TIME_W:0]    load_sum;
   logic [CNW-1:0]     count_eff;
   logic               release_ev, preempt_ev;
   logic               push_req, push_ok;
   logic [AW-1:0]      push_task;
   logic               pop_en;
   logic               rem_dec;
   logic [TIME_W-1:0]  tick_next;

   assign idx_w     = IXW'(req_task_index);
   assign load_ok   = cmd.load && (idx_w < IXW'(MAX_TASKS));
   assign load_addr = idx_w[AW-1:0];
   assign load_sum  = {1'b0, req_arrival_time} + {1'b0, req_burst_length};

   assign count_eff = (CNW'(task_count_ff) > CNW'(MAX_TASKS)) ?
                      CNW'(MAX_TASKS) : CNW'(task_count_ff);

   assign status.count_zero = (task_count_ff == '0);
   assign status.scan_last  = ((CNW'(scan_ff) + CNW'(1)) == count_eff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // release on no work left, else preempt when the slice is spent
   assign release_ev = cmd.check && busy_ff && (rem_rd == '0);
   assign preempt_ev = cmd.check && busy_ff && (rem_rd != '0) && (slice_ff >= quantum_ff);

   always_comb begin
      push_req  = 1'b0;
      push_task = cur_ff;
      if (preempt_ev) begin
         push_req = 1'b1;
      end else if (cmd.scan_step && arr_rd == tick_ff) begin
         push_req  = 1'b1;
         push_task = scan_ff;
      end
   end

   assign push_ok   = push_req && (fill_ff < FW'(MAX_TASKS));
   assign pop_en    = cmd.dispatch && !busy_ff && (fill_ff != '0);
   assign rem_dec   = cmd.run && busy_ff && (rem_rd != '0);
   assign tick_next = tick_ff + TIME_W'(1);

   // arrival scan pointer doubles as the arrival table read address
   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_step && !status.scan_last) begin
         scan_in = scan_ff + AW'(1);
      end
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      cur_in     = cur_ff;
      busy_in    = busy_ff;
      slice_in   = slice_ff;
      tick_in    = tick_ff;
      preempt_in = preempt_ff;
      latest_in  = latest_ff;
      if (load_ok && load_sum > latest_ff) begin
         latest_in = load_sum;
      end
      if (release_ev || preempt_ev) begin
         busy_in  = 1'b0;
         slice_in = '0;
      end
      if (preempt_ev && preempt_ff != '1) begin
         preempt_in = preempt_ff + TIME_W'(1);
      end
      if (push_ok) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);
         fill_in = fill_ff + FW'(1);
      end
      if (pop_en) begin
         cur_in   = q_rd;
         busy_in  = 1'b1;
         slice_in = '0;
         head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
         fill_in  = fill_ff - FW'(1);
      end
      if (cmd.run) begin
         tick_in = tick_next;
         if (busy_ff && slice_ff != '1) begin
            slice_in = slice_ff + QUANT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff    <= QUANTUM_RESET;
         task_count_ff <= TASK_COUNT_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         cur_ff        <= '0;
         busy_ff       <= 1'b0;
         slice_ff      <= '0;
         tick_ff       <= '0;
         preempt_ff    <= '0;
         latest_ff     <= '0;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_QUANTUM:    quantum_ff    <= csr_data;
               CSR_TASK_COUNT: task_count_ff <= csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         cur_ff       <= cur_in;
         busy_ff      <= busy_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         preempt_ff   <= preempt_in;
         latest_ff    <= latest_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.run) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (cmd.run) begin
         rsp_time_ff   <= tick_ff;
         rsp_task_ff   <= busy_ff ? TASK_W'(cur_ff) : '0;
         rsp_run_ff    <= busy_ff;
         rsp_switch_ff <= preempt_ff;
         rsp_done_ff   <= ({1'b0, tick_next} >= latest_ff) && !busy_ff && (fill_ff == '0);
      end
   end

   // remaining table: load write or one-tick decrement, never together
   always_comb begin
      rem_we = load_ok || rem_dec;
      rem_wa = load_ok ? load_addr : cur_ff;
      rem_wd = load_ok ? req_burst_length : rem_rd - TIME_W'(1);
   end

   rrts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_arrival (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (load_addr),
      .wr_data (req_arrival_time),
      .rd_addr (scan_in),
      .rd_data (arr_rd)
   );

   rrts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_remaining (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_wa),
      .wr_data (rem_wd),
      .rd_addr (cur_ff),
      .rd_data (rem_rd)
   );

   rrts_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_queue (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (tail_ff),
      .wr_data (push_task),
      .rd_addr (head_ff),
      .rd_data (q_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_time  = rsp_time_ff;
   assign rsp_running_task  = rsp_task_ff;
   assign rsp_running_valid = rsp_run_ff;
   assign rsp_switch_count  = rsp_switch_ff;
   assign rsp_all_done      = rsp_done_ff;

endmodule

// ----- rtl/round_robin_task_scheduler_unit.sv -----
// Top level of the round-robin task scheduler.
// Depends on rrts_pkg, rrts_ctrl, rrts_dpath (which uses rrts_ram).
//
// Round-robin time-slice scheduler. A load request (kind 0) stores a task's
// arrival tick and burst length and produces no response. A tick request
// (kind 1) releases a finished task or preempts one whose slice reached the
// quantum to the tail of the ready FIFO, enqueues every task in use whose
// arrival equals the current time in index order, dispatches the queue head
// if the processor is idle, then charges one tick and returns one response
// with time, running task, switch count and a done flag. A tick passes
// through the check, scan, queue wait, dispatch, remaining-table wait and
// run states before the response is loaded (no scan when task_count is 0):
// the arrival table is walked one entry per cycle through its single read
// port, task_count entries capped at MAX_TASKS, plus steps for release,
// queue and table read latency, and the update. The next request is taken
// as soon as the sequencer is back in idle, even while the last response
// still waits for rsp_ready; a tick that finishes while the response
// register is full holds until it drains.
// Configuration writes are always accepted (csr_ready is tied high):
// index 0 quantum, index 1 task_count; other indexes are ignored. Table
// entries read before being loaded are undefined.
module round_robin_task_scheduler_unit
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [TASK_W-1:0]   req_task_index,
   input  logic [TIME_W-1:0]   req_arrival_time,
   input  logic [TIME_W-1:0]   req_burst_length,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TIME_W-1:0]   rsp_current_time,
   output logic [TASK_W-1:0]   rsp_running_task,
   output logic                rsp_running_valid,
   output logic [TIME_W-1:0]   rsp_switch_count,
   output logic                rsp_all_done,
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_data
);

   cmd_type    cmd;
   status_type status;

   // register writes always land, no backpressure needed
   assign csr_ready = 1'b1;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // load writes are qualified inside by the transfer (cmd.load)
   rrts_dpath #(.MAX_TASKS(MAX_TASKS)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_task_index    (req_task_index),
      .req_arrival_time  (req_arrival_time),
      .req_burst_length  (req_burst_length),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_time  (rsp_current_time),
      .rsp_running_task  (rsp_running_task),
      .rsp_running_valid (rsp_running_valid),
      .rsp_switch_count  (rsp_switch_count),
      .rsp_all_done      (rsp_all_done)
   );

endmodule
